FILE: rtl/pse_pkg.sv
// Shared types, constants and helper functions of the systematic polar encoder.
package pse_pkg;

    localparam int CODE_LENGTH = 64;
    localparam int IDX_W       = 6;
    localparam int PTR_W       = 7;

    typedef logic [CODE_LENGTH-1:0] t_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEEK,
        ST_CHECK,
        ST_SOLVE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic ptr_step;
        logic place;
        logic solve_init;
        logic solve_step;
        logic emit_init;
        logic emit_step;
        logic frame_clear;
    } t_cmd;

    typedef struct packed {
        logic ptr_end;
        logic ptr_frozen;
        logic idx_zero;
        logic idx_last;
    } t_status;

    // Bit j is set when index j covers every one bit of idx, i.e. the rows
    // of the polar generator that reach column idx.
    function automatic t_word f_sup_mask(input logic [IDX_W-1:0] idx);
        t_word m;
        m = '0;
        for (int j = 0; j < CODE_LENGTH; j++) begin
            m[j] = ((IDX_W'(j) & idx) == idx);
        end
        return m;
    endfunction

endpackage

FILE: rtl/polar_systematic_encoder_core.sv
// Top level of the systematic polar encoder: controller plus datapath.
//
//  Channel   Direction  Handshake                      Payload
//  --------  ---------  -----------------------------  ---------------------------------
//  input     in         start high while busy is low   i_info_bit
//  result    out        o_strobe, one cycle per item   o_code_bit, o_code_index, o_code_last
//  config    in         i_cfg_we                       i_cfg_wdata (frozen mask)
//
// An item is taken in during an idle cycle. The seek state then walks to the next
// free position and places it there, and the check state looks for a free position
// after it; both step over frozen positions one by one. Frozen positions that lie
// between two free ones are walked twice, once after the earlier item is placed
// and again by the search of the next item.
// When the frame closes, the solve finds one source bit per cycle through the shared
// parity tree, from the top index down, and the emission then gives one code bit per
// cycle, each shown on the output registers in the cycle after it is computed.
// Reset is synchronous and active low; it clears the mask, the frame and the
// controller. The receiver cannot stall, so no item is ever held back at the output.
module polar_systematic_encoder_core
    import pse_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_info_bit,
    input  logic             i_cfg_we,
    input  t_word            i_cfg_wdata,
    output logic             o_strobe,
    output logic             o_code_bit,
    output logic [IDX_W-1:0] o_code_index,
    output logic             o_code_last
);

    t_cmd    cmd;
    t_status status;

    // The controller sequences loading, the back substitution and the emission.
    pse_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // The datapath holds all frame state and computes each bit with one
    // masked parity over the source word.
    pse_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_info_bit   (i_info_bit),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_strobe     (o_strobe),
        .o_code_bit   (o_code_bit),
        .o_code_index (o_code_index),
        .o_code_last  (o_code_last)
    );

endmodule

FILE: rtl/pse_ctrl.sv
// Controller state machine of the systematic polar encoder.
module pse_ctrl
    import pse_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_SEEK;
                end
            end
            ST_SEEK: begin
                // No free position left: the item is dropped and the frame closes.
                if (i_status.ptr_end) begin
                    o_cmd.solve_init = 1'b1;
                    n_state          = ST_SOLVE;
                end else if (i_status.ptr_frozen) begin
                    o_cmd.ptr_step = 1'b1;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state     = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_status.ptr_end) begin
                    o_cmd.solve_init = 1'b1;
                    n_state          = ST_SOLVE;
                end else if (i_status.ptr_frozen) begin
                    o_cmd.ptr_step = 1'b1;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SOLVE: begin
                o_cmd.solve_step = 1'b1;
                if (i_status.idx_zero) begin
                    o_cmd.emit_init = 1'b1;
                    n_state         = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_cmd.emit_step = 1'b1;
                if (i_status.idx_last) begin
                    o_cmd.frame_clear = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/pse_dp.sv
// Datapath of the systematic polar encoder: mask, frame, source bits and the parity unit.
module pse_dp
    import pse_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_word            i_cfg_wdata,
    input  logic             i_info_bit,
    input  t_cmd             i_cmd,
    output t_status          o_status,
    output logic             o_strobe,
    output logic             o_code_bit,
    output logic [IDX_W-1:0] o_code_index,
    output logic             o_code_last
);

    t_word            r_mask;
    t_word            r_frame;
    t_word            r_u;
    logic [PTR_W-1:0] r_fill;
    logic [PTR_W-1:0] r_ptr;
    logic [IDX_W-1:0] r_idx;
    logic             r_bit;
    logic             r_strobe;
    logic             r_code_bit;
    logic [IDX_W-1:0] r_code_index;
    logic             r_code_last;

    logic [IDX_W-1:0] ptr_pos;
    logic             parity;
    logic             idx_last;

    assign ptr_pos  = r_ptr[IDX_W-1:0];
    // One XOR tree serves both the back substitution and the code bit output.
    assign parity   = ^(r_u & f_sup_mask(r_idx));
    assign idx_last = (r_idx == IDX_W'(CODE_LENGTH - 1));

    assign o_status.ptr_end    = (r_ptr == PTR_W'(CODE_LENGTH));
    assign o_status.ptr_frozen = r_mask[ptr_pos];
    assign o_status.idx_zero   = (r_idx == '0);
    assign o_status.idx_last   = idx_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask   <= '0;
            r_frame  <= '0;
            r_fill   <= '0;
            r_strobe <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mask <= i_cfg_wdata;
            end
            if (i_cmd.frame_clear) begin
                r_frame <= '0;
                r_fill  <= '0;
            end else if (i_cmd.place) begin
                r_frame[ptr_pos] <= r_bit;
                r_fill           <= r_ptr + PTR_W'(1);
            end
            r_strobe <= i_cmd.emit_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_bit <= i_info_bit;
            r_ptr <= r_fill;
        end else if (i_cmd.ptr_step || i_cmd.place) begin
            r_ptr <= r_ptr + PTR_W'(1);
        end

        if (i_cmd.solve_init) begin
            r_u <= '0;
        end else if (i_cmd.solve_step) begin
            // Source bits are found from the top index down; frozen ones stay zero.
            r_u[r_idx] <= ~r_mask[r_idx] & (r_frame[r_idx] ^ parity);
        end

        if (i_cmd.solve_init) begin
            r_idx <= IDX_W'(CODE_LENGTH - 1);
        end else if (i_cmd.emit_init) begin
            r_idx <= '0;
        end else if (i_cmd.solve_step) begin
            r_idx <= r_idx - IDX_W'(1);
        end else if (i_cmd.emit_step) begin
            r_idx <= r_idx + IDX_W'(1);
        end

        if (i_cmd.emit_step) begin
            r_code_bit   <= parity;
            r_code_index <= r_idx;
            r_code_last  <= idx_last;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_code_bit   = r_code_bit;
    assign o_code_index = r_code_index;
    assign o_code_last  = r_code_last;

endmodule

FILE: rtl/pse_chk.sv
// Port-level checker of the systematic polar encoder and its bind.
module pse_chk
    import pse_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_strobe,
    input logic [IDX_W-1:0] o_code_index,
    input logic             o_code_last
);

    // A frame is emitted without gaps.
    a_emit_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_code_last |=> o_strobe)
        else $error("code bits of a frame are not contiguous");

    // Positions rise by one within a frame.
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_code_last |=> o_code_index == IDX_W'($past(o_code_index) + IDX_W'(1)))
        else $error("code index did not advance by one");

    // The last marker sits on the final position only.
    a_last_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_code_last == (o_code_index == IDX_W'(CODE_LENGTH - 1))))
        else $error("last marker on the wrong position");

    // A taken item keeps the block busy for the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("block not busy after taking an item");

endmodule

bind polar_systematic_encoder_core pse_chk u_pse_chk (.*);

FILE: bench/polar_codeword_checker.sv
// Checker for the systematic polar encoder: predicts every code bit item and compares it.
`timescale 1ns / 100ps

module polar_codeword_checker
    import pse_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  logic             i_info_bit,
    input  logic             i_cfg_we,
    input  t_word            i_cfg_wdata,
    input  logic             i_strobe,
    input  logic             i_code_bit,
    input  logic [IDX_W-1:0] i_code_index,
    input  logic             i_code_last,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic             code_bit;
        logic [IDX_W-1:0] code_index;
        logic             code_last;
    } t_code_item;

    t_word      mask_q  = '0;
    t_word      frame_q = '0;
    int         fill_q  = 0;
    t_code_item codeword_fifo[$];

    // First position at or after 'from' that the current mask leaves open, or -1.
    function automatic int next_free(input int from);
        for (int p = from; p < CODE_LENGTH; p++) begin
            if (!mask_q[p]) begin
                return p;
            end
        end
        return -1;
    endfunction

    // Systematic solve in natural order. Column j of the generator collects
    // every row i that covers the bits of j, so x[j] is the parity of u[i]
    // over those rows. Walking open positions from the top down gives each
    // source bit from the data bit and the source bits already fixed above.
    function automatic t_word solve_codeword(input t_word data, input t_word mask);
        t_word u;
        t_word x;
        logic  acc;
        u = '0;
        x = '0;
        for (int j = CODE_LENGTH - 1; j >= 0; j--) begin
            if (!mask[j]) begin
                acc = 1'b0;
                for (int i = j + 1; i < CODE_LENGTH; i++) begin
                    if ((i & j) == j) acc ^= u[i];
                end
                u[j] = data[j] ^ acc;
            end
        end
        for (int j = 0; j < CODE_LENGTH; j++) begin
            acc = 1'b0;
            for (int i = j; i < CODE_LENGTH; i++) begin
                if ((i & j) == j) acc ^= u[i];
            end
            x[j] = acc;
        end
        return x;
    endfunction

    function automatic void queue_codeword();
        t_word      x;
        t_code_item item;
        x = solve_codeword(frame_q, mask_q);
        for (int j = 0; j < CODE_LENGTH; j++) begin
            item.code_bit   = x[j];
            item.code_index = IDX_W'(j);
            item.code_last  = (j == CODE_LENGTH - 1);
            codeword_fifo.insert(codeword_fifo.size(), item);
        end
        frame_q = '0;
        fill_q  = 0;
    endfunction

    always @(posedge i_clk) begin
        t_code_item got;
        t_code_item want;
        int         pos;
        if (!i_rst_n) begin
            mask_q  = '0;
            frame_q = '0;
            fill_q  = 0;
            codeword_fifo.delete();
        end else begin
            if (i_cfg_we) mask_q = i_cfg_wdata;

            if (i_strobe) begin
                got = '{i_code_bit, i_code_index, i_code_last};
                if (codeword_fifo.size() == 0) begin
                    o_fail_count++;
                    $display("%0t ns: expected no item, got %0b/%0d/%0b (bit/index/last)",
                             $time, got.code_bit, got.code_index, got.code_last);
                end else begin
                    want = codeword_fifo.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        $display("%0t ns: expected %0b/%0d/%0b, got %0b/%0d/%0b (bit/index/last)",
                                 $time, want.code_bit, want.code_index, want.code_last,
                                 got.code_bit, got.code_index, got.code_last);
                    end
                end
            end

            if (i_start && !i_busy) begin
                pos = next_free(fill_q);
                if (pos < 0) begin
                    // Nothing open is left in this frame: the bit is dropped.
                    queue_codeword();
                end else begin
                    frame_q[pos] = i_info_bit;
                    fill_q       = pos + 1;
                    if (next_free(fill_q) < 0) queue_codeword();
                end
            end
        end
        o_pending = codeword_fifo.size();
    end

endmodule

FILE: bench/polar_systematic_encoder_core_tb.sv
// Testbench top for the systematic polar encoder: stimulus, clock, reset and verdict.
`timescale 1ns / 100ps

module polar_systematic_encoder_core_tb;
    import pse_pkg::*;

    // The longest item walks the whole mask, and a closing item adds the
    // solve plus 64 emitted bits. The sender first waits until the checker
    // expects nothing and the block is idle, so the further quiet wait of
    // SETTLE_CYCLES only guards against a late or stray code item.
    localparam int SETTLE_CYCLES = 160;
    // Run length limit; the watchdog below fails the run when it is reached.
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_ITEMS  = 280;

    typedef enum int {
        MASK_OPEN,
        MASK_SHUT,
        MASK_SPARSE_OPEN,
        MASK_HALF,
        MASK_MOSTLY_OPEN,
        MASK_SINGLE_OPEN
    } t_mask_kind;

    typedef enum int {
        PATTERN_ZEROS,
        PATTERN_ONES,
        PATTERN_RANDOM
    } t_bit_pattern;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    logic             i_info_bit  = 1'b0;
    logic             i_cfg_we    = 1'b0;
    t_word            i_cfg_wdata = '0;
    logic             busy;
    logic             o_strobe;
    logic             o_code_bit;
    logic [IDX_W-1:0] o_code_index;
    logic             o_code_last;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int burst_left  = 1;

    always #6 i_clk = ~i_clk;

    polar_systematic_encoder_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_info_bit   (i_info_bit),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_strobe     (o_strobe),
        .o_code_bit   (o_code_bit),
        .o_code_index (o_code_index),
        .o_code_last  (o_code_last)
    );

    // The checker watches every channel on its own and keeps the expected
    // code items; this module only drives the block and reads the totals.
    polar_codeword_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_info_bit   (i_info_bit),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_strobe     (o_strobe),
        .i_code_bit   (o_code_bit),
        .i_code_index (o_code_index),
        .i_code_last  (o_code_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // A hung block must not hang the run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offers one item and returns at the edge that takes it. Start stays high
    // afterwards so that back-to-back items in a burst need no gap between them;
    // at the end of a burst it drops for a random gap.
    task automatic send_item(input logic info);
        start      <= 1'b1;
        i_info_bit <= info;
        do @(posedge i_clk); while (busy);
        burst_left--;
        if (burst_left <= 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            // Every so often a long burst with no gaps at all.
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
        end
    endtask

    // Holds the sender off until every expected code item has come back and
    // the block has gone quiet, so that the mask may be rewritten safely.
    task automatic settle_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mask(input t_word mask);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mask;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        t_word        mask;
        t_mask_kind   kind;
        t_bit_pattern pattern;
        int           open_count;
        int           item_count;
        int           sent;
        logic         info;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every position frozen: each item is dropped and an all-zero frame
        // comes out at once.
        write_mask('1);
        send_item(1'b1);
        send_item(1'b0);

        // Only the top position open: one item closes each frame.
        settle_idle();
        write_mask(64'h7FFF_FFFF_FFFF_FFFF);
        send_item(1'b1);
        send_item(1'b0);

        // Only position zero open: its source bit reaches no other column.
        settle_idle();
        write_mask(64'hFFFF_FFFF_FFFF_FFFE);
        send_item(1'b1);

        // Mask rewritten mid-frame. Three bits land at 0..2; the new mask
        // freezes position 1, whose placed one must then have no effect, and
        // the next free position jumps to the top, which closes the frame.
        settle_idle();
        write_mask(~64'h0000_0000_0000_F00F);
        send_item(1'b1);
        send_item(1'b1);
        send_item(1'b0);
        settle_idle();
        write_mask(~64'h8000_0000_0000_0005);
        send_item(1'b1);

        // Mask rewritten so that nothing is open past the fill point: the
        // next item is dropped and the frame goes out right away.
        settle_idle();
        write_mask(~64'h0000_0000_0000_000F);
        send_item(1'b1);
        send_item(1'b1);
        settle_idle();
        write_mask(~64'h0000_0000_0000_0003);
        send_item(1'b1);

        // Random phases. Most send whole frames' worth of items; some stop
        // part way so that the following mask write lands mid-frame.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            settle_idle();
            kind = t_mask_kind'($urandom_range(0, 5));
            case (kind)
                MASK_OPEN: begin
                    mask = '0;
                end
                MASK_SHUT: begin
                    mask = '1;
                end
                MASK_SPARSE_OPEN: begin
                    mask = {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
                end
                MASK_HALF: begin
                    mask = {$urandom, $urandom};
                end
                MASK_MOSTLY_OPEN: begin
                    mask = {$urandom, $urandom} & {$urandom, $urandom};
                end
                default: begin
                    mask = ~(t_word'(1) << $urandom_range(0, CODE_LENGTH - 1));
                end
            endcase
            write_mask(mask);

            open_count = $countones(~mask);
            if (open_count == 0) begin
                item_count = $urandom_range(1, 4);
            end else if ($urandom_range(0, 3) == 0) begin
                item_count = $urandom_range(1, open_count);
            end else if (open_count > 32) begin
                item_count = open_count;
            end else begin
                item_count = open_count * $urandom_range(1, 3);
            end
            if (item_count > RANDOM_ITEMS - sent) begin
                item_count = RANDOM_ITEMS - sent;
            end

            pattern = t_bit_pattern'($urandom_range(0, 4) > 2 ? $urandom_range(0, 1)
                                                              : PATTERN_RANDOM);
            for (int k = 0; k < item_count; k++) begin
                case (pattern)
                    PATTERN_ZEROS: info = 1'b0;
                    PATTERN_ONES:  info = 1'b1;
                    default:       info = 1'($urandom_range(0, 1));
                endcase
                send_item(info);
                sent++;
            end
        end

        settle_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
